// ===== src/perturbed_crc32_stream_assert.svh =====
// Assertion macros shared by the checker of the perturbed CRC32 stream block.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef PERTURBED_CRC32_STREAM_ASSERT_SVH
`define PERTURBED_CRC32_STREAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCRC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("pcrc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("pcrc assertion failed");

`endif

// ===== src/pcrc_pkg.sv =====
// Shared types, register codes, reset values and checksum functions
// for the perturbed CRC32 stream block. No dependencies.
package pcrc_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [31:0] POLY_RESET  = 32'h82F6_3B78;
    localparam logic [31:0] INIT_RESET  = 32'hDEAD_BEEF;
    localparam logic [7:0]  MASK_RESET  = 8'hA5;
    localparam logic [31:0] ROUND_RESET = 32'hA5A5_A5A5;
    localparam logic [4:0]  SHIFT_RESET = 5'd7;
    localparam logic [31:0] FINAL_RESET = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        REG_POLY  = 3'd0,
        REG_INIT  = 3'd1,
        REG_MASK  = 3'd2,
        REG_ROUND = 3'd3,
        REG_SHIFT = 3'd4,
        REG_FINAL = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] polynomial;
        logic [31:0] initial_value;
        logic [7:0]  byte_mask;
        logic [31:0] round_xor;
        logic [4:0]  shift_amount;
        logic [31:0] final_xor;
    } cfg_t;

    // Table entry built on the fly: eight reflected shift-and-XOR steps.
    function automatic logic [31:0] crc_entry(input logic [7:0] idx,
                                              input logic [31:0] poly);
        logic [31:0] v;
        v = {24'd0, idx};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [31:0] crc_update(input logic [31:0] crc,
                                               input logic [7:0]  data,
                                               input cfg_t        cfg);
        logic [7:0] masked;
        masked = data ^ cfg.byte_mask;
        return (crc >> cfg.shift_amount)
             ^ crc_entry(crc[7:0] ^ masked, cfg.polynomial)
             ^ cfg.round_xor;
    endfunction

endpackage

// ===== src/pcrc_regs.sv =====
// APB-style configuration register file of the perturbed CRC32 stream block.
// Depends on pcrc_pkg for the register codes, reset values and cfg_t.
module pcrc_regs import pcrc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_POLY:  cfg_next.polynomial    = pwdata;
                REG_INIT:  cfg_next.initial_value = pwdata;
                REG_MASK:  cfg_next.byte_mask     = pwdata[7:0];
                REG_ROUND: cfg_next.round_xor     = pwdata;
                REG_SHIFT: cfg_next.shift_amount  = pwdata[4:0];
                REG_FINAL: cfg_next.final_xor     = pwdata;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_POLY:  prdata = cfg_reg.polynomial;
            REG_INIT:  prdata = cfg_reg.initial_value;
            REG_MASK:  prdata = {24'd0, cfg_reg.byte_mask};
            REG_ROUND: prdata = cfg_reg.round_xor;
            REG_SHIFT: prdata = {27'd0, cfg_reg.shift_amount};
            REG_FINAL: prdata = cfg_reg.final_xor;
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polynomial    <= POLY_RESET;
            cfg_reg.initial_value <= INIT_RESET;
            cfg_reg.byte_mask     <= MASK_RESET;
            cfg_reg.round_xor     <= ROUND_RESET;
            cfg_reg.shift_amount  <= SHIFT_RESET;
            cfg_reg.final_xor     <= FINAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/perturbed_crc32_stream.sv =====
// Perturbed CRC32 stream: takes one message byte per word and folds it into a
// running checksum in the same cycle. Throughput is one word per cycle while
// the skid register is empty; the cycle is set by the eight-step table entry
// feeding the checksum register. Once its last word is accepted, a result is
// registered into m_*; a skid register lets input continue for one result
// while the output stalls. Synchronous reset restores the configuration
// registers, empties the output and sets the checksum to 0xDEADBEEF.
module perturbed_crc32_stream import pcrc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_first_byte,
    input  logic               s_last_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_checksum
);

    cfg_t        cfg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_base;
    logic [31:0] result;
    logic        accept;
    logic        emit;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] m_checksum_reg;
    logic [31:0] m_checksum_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic [31:0] skid_checksum_reg;
    logic [31:0] skid_checksum_next;

    pcrc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready    = !skid_valid_reg;
    assign accept     = s_valid && s_ready;
    assign emit       = accept && s_last_byte;
    assign m_valid    = m_valid_reg;
    assign m_checksum = m_checksum_reg;

    assign crc_base = s_first_byte ? cfg.initial_value : crc_reg;
    assign crc_next = accept ? crc_update(crc_base, s_data_byte, cfg) : crc_reg;
    assign result   = crc_update(crc_base, s_data_byte, cfg) ^ cfg.final_xor;

    // The output register refills from the skid word first, which keeps order.
    always_comb begin
        m_valid_next       = m_valid_reg;
        m_checksum_next    = m_checksum_reg;
        skid_valid_next    = skid_valid_reg;
        skid_checksum_next = skid_checksum_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_checksum_next = skid_checksum_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next    = emit;
                m_checksum_next = result;
            end
        end else if (emit) begin
            skid_valid_next    = 1'b1;
            skid_checksum_next = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg        <= INIT_RESET;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            crc_reg        <= crc_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_checksum_reg    <= m_checksum_next;
        skid_checksum_reg <= skid_checksum_next;
    end

endmodule

// ===== src/pcrc_checker.sv =====
// Port-level checker for the perturbed CRC32 stream block, bound to the top.
// Depends on perturbed_crc32_stream_assert.svh for the assertion macros.
`include "perturbed_crc32_stream_assert.svh"

module pcrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_checksum
);

    // A stalled result word must hold.
    `PCRC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_checksum))

    // Input only stalls when both the output and the skid word are occupied.
    `PCRC_ASSERT_SAME(a_stall_needs_output, !s_ready, m_valid)

    // A last word always leaves the output valid in the next cycle.
    `PCRC_ASSERT_NEXT(a_last_emits, s_valid && s_ready && s_last_byte, m_valid)

    // A middle word into an empty output produces nothing.
    `PCRC_ASSERT_NEXT(a_mid_silent, s_valid && s_ready && !s_last_byte && !m_valid, !m_valid)

endmodule

bind perturbed_crc32_stream pcrc_checker u_checker (.*);
